// File: rtl/blifo_pkg.sv
// Package: types, sizes and codes shared by the LIFO stack modules.
`timescale 1ns / 1ps
`default_nettype none

package blifo_pkg;

	localparam int DEPTH      = 256;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int LIMIT_W    = 9;
	localparam int APB_AW     = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

	localparam logic [1:0] REQ_PUSH = 2'd0;
	localparam logic [1:0] REQ_POP  = 2'd1;
	localparam logic [1:0] REQ_PEEK = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [1:0] ST_RANGE     = 2'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] push_value;
		logic [7:0]         peek_index;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [1:0]         status;
		logic [8:0]         fill_level;
		logic               is_empty;
		logic               is_full;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

`default_nettype wire

// File: rtl/bounded_lifo_stack.sv
// Top level: bounded LIFO stack with APB limit register.
//
//  channel   signals                        word
//  request   req_valid / req_ready          req_data  (req_t)
//  response  rsp_valid / rsp_ready          rsp_data  (rsp_t)
//  config    psel penable pwrite paddr ...  stack_limit at byte address 0
//
//  Each request passes through accept, one storage access and response.
//  The registered read of the entry RAM needs the separate response step.
//  A new request is taken only after the previous response is taken.
//  Reset clears the fill count and sets the limit to 256; no clearing pass.
//  A stalled response holds its word until rsp_ready is high.
`timescale 1ns / 1ps
`default_nettype none

module bounded_lifo_stack
	import blifo_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire req_t              req_data,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output rsp_t                   rsp_data,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	cmd_t               cmd;
	logic               cfg_we;
	logic [LIMIT_W-1:0] limit;

	// the limit register sits at byte address 0
	assign cfg_we = psel && penable && pwrite && (paddr == '0);
	assign pready = 1'b1;
	assign prdata = 32'(limit);

	blifo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	blifo_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (pwdata[LIMIT_W-1:0]),
		.limit     (limit),
		.rsp       (rsp_data)
	);

endmodule

`default_nettype wire

// File: rtl/blifo_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module blifo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/blifo_ctrl.sv
// Controller: sequences accept, execute and respond for one word at a time.
`timescale 1ns / 1ps
`default_nettype none

module blifo_ctrl
	import blifo_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: state_d = S_RESP;
			S_RESP: begin
				if (rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_RESP);
	assign cmd.load  = req_ready && req_valid;
	assign cmd.exec  = (state_q == S_EXEC);

endmodule

`default_nettype wire

// File: rtl/blifo_dp.sv
// Datapath: request register, stack pointer, limit register, storage and result.
`timescale 1ns / 1ps
`default_nettype none

module blifo_dp
	import blifo_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	input  wire req_t               req,
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_wdata,
	output logic      [LIMIT_W-1:0] limit,
	output rsp_t                    rsp
);

	req_t               req_q;
	logic [CNT_W-1:0]   top_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [1:0]         status_q;
	logic [CNT_W-1:0]   fill_q;
	logic               empty_q;
	logic               full_q;
	logic               rd_sel_q;

	logic [CNT_W-1:0]      cap;
	logic [CNT_W-1:0]      top_d;
	logic [CNT_W-1:0]      peek_cnt;
	logic [CNT_W-1:0]      rd_cnt;
	logic [1:0]            status_d;
	logic                  wr_ok;
	logic                  rd_ok;
	logic [DATA_WIDTH-1:0] wdata;
	logic [DATA_WIDTH-1:0] rdata;

	// capacity saturates at the storage depth
	assign cap = (32'(limit_q) > 32'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(limit_q);
	assign peek_cnt = CNT_W'(req_q.peek_index);
	assign wdata = DATA_WIDTH'($unsigned(req_q.push_value));

	always_comb begin
		top_d    = top_q;
		status_d = ST_OK;
		wr_ok    = 1'b0;
		rd_ok    = 1'b0;
		rd_cnt   = top_q - CNT_W'(1);
		case (req_q.req_type)
			REQ_PUSH: begin
				if (top_q >= cap || 32'(top_q) >= 32'(DEPTH)) begin
					status_d = ST_OVERFLOW;
				end else begin
					wr_ok = 1'b1;
					top_d = top_q + CNT_W'(1);
				end
			end
			REQ_POP: begin
				if (top_q == '0) begin
					status_d = ST_UNDERFLOW;
				end else begin
					rd_ok = 1'b1;
					top_d = top_q - CNT_W'(1);
				end
			end
			REQ_PEEK: begin
				if (peek_cnt < top_q) begin
					rd_ok  = 1'b1;
					rd_cnt = top_q - CNT_W'(1) - peek_cnt;
				end else begin
					status_d = ST_RANGE;
				end
			end
			default: ;
		endcase
	end

	blifo_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH),
		.AW    (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (cmd.exec && wr_ok),
		.waddr (top_q[ADDR_W-1:0]),
		.wdata (wdata),
		.re    (cmd.exec && rd_ok),
		.raddr (rd_cnt[ADDR_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= '0;
			limit_q <= LIMIT_RESET;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				top_q <= top_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.exec) begin
			status_q <= status_d;
			fill_q   <= top_d;
			empty_q  <= (top_d == '0);
			full_q   <= (top_d >= cap);
			rd_sel_q <= rd_ok;
		end
	end

	// read data holds in the RAM output register until the next read
	assign rsp.read_value = rd_sel_q ? 32'(rdata) : 32'sd0;
	assign rsp.status     = status_q;
	assign rsp.fill_level = 9'(fill_q);
	assign rsp.is_empty   = empty_q;
	assign rsp.is_full    = full_q;
	assign limit          = limit_q;

endmodule

`default_nettype wire
